### hw/rtl/qalu_pkg.sv
// Shared constants, command codes, product sign tables and sideband types
// for the quaternion ALU. No dependencies.
package qalu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DATA_W    = 32;
  localparam int Q_W       = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int CMD_W     = 3;

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int LO_W   = SUM_W / 2;
  localparam int HI_W   = SUM_W - LO_W;
  localparam int PH_W   = HI_W + DATA_W;
  localparam int PL_W   = LO_W + 1 + DATA_W;
  localparam int PP_W   = PH_W + LO_W;
  localparam int NUM_W  = PP_W + 2;
  localparam int DEN_W  = PROD_W + 1;
  localparam int REM_W  = DEN_W + 1;

  localparam int IN_DATA_W  = 8 * DATA_W;
  localparam int OUT_DATA_W = 4 * DATA_W;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INV = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ROT = 3'd5;

  localparam logic [1:0] COMP_W = 2'd3;

  // Hamilton product r = p*q: result r takes p[j] times q[QIDX[r][j]],
  // subtracted where QNEG[r][j] is set. Component order is x, y, z, w.
  localparam logic [1:0] QIDX [4][4] = '{
    '{2'd3, 2'd2, 2'd1, 2'd0},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd0, 2'd1, 2'd2, 2'd3}
  };
  localparam logic QNEG [4][4] = '{
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b1, 1'b0, 1'b0, 1'b0},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic [3:0] neg;
    logic [3:0] ovf;
    logic       dz;
    logic       zero;
  } side_t;

endpackage

### hw/rtl/qalu_divider.sv
// Pipelined restoring divider for the four result components, one quotient
// bit per stage. Depends on qalu_pkg.
module qalu_divider (
  input  logic                       clk,
  input  logic [qalu_pkg::Q_W-1:0]   en,
  input  logic [qalu_pkg::REM_W-1:0] rem_in [4],
  input  logic [qalu_pkg::Q_W-1:0]   qs_in [4],
  input  logic [qalu_pkg::DEN_W-1:0] den_in,
  input  qalu_pkg::side_t            side_in,
  output logic [qalu_pkg::REM_W-1:0] rem_out [4],
  output logic [qalu_pkg::Q_W-1:0]   qs_out [4],
  output logic [qalu_pkg::DEN_W-1:0] den_out,
  output qalu_pkg::side_t            side_out
);
  import qalu_pkg::*;

  logic [REM_W-1:0] rem_q [Q_W][4];
  logic [Q_W-1:0]   qs_q [Q_W][4];
  logic [DEN_W-1:0] den_q [Q_W];
  side_t            side_q [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [REM_W-1:0] rem_d [4];
    logic [Q_W-1:0]   qs_d [4];
    logic [DEN_W-1:0] den_d;
    side_t            side_d;
    logic [REM_W-1:0] t [4];
    logic             ge [4];

    if (i == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          rem_d[k] = rem_in[k];
          qs_d[k]  = qs_in[k];
        end
        den_d  = den_in;
        side_d = side_in;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          rem_d[k] = rem_q[i-1][k];
          qs_d[k]  = qs_q[i-1][k];
        end
        den_d  = den_q[i-1];
        side_d = side_q[i-1];
      end
    end

    // The numerator bits wait at the top of qs; quotient bits fill the bottom.
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        t[k]  = {rem_d[k][REM_W-2:0], qs_d[k][Q_W-1]};
        ge[k] = (t[k] >= REM_W'(den_d));
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        for (int k = 0; k < 4; k++) begin
          rem_q[i][k] <= ge[k] ? (t[k] - REM_W'(den_d)) : t[k];
          qs_q[i][k]  <= {qs_d[k][Q_W-2:0], ge[k]};
        end
        den_q[i]  <= den_d;
        side_q[i] <= side_d;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rem_out[k] = rem_q[Q_W-1][k];
      qs_out[k]  = qs_q[Q_W-1][k];
    end
    den_out  = den_q[Q_W-1];
    side_out = side_q[Q_W-1];
  end

endmodule

### hw/rtl/quaternion_alu_core.sv
// Top level of the quaternion ALU: operand products, numerator build,
// divider and rounding. Depends on qalu_pkg and qalu_divider.
//
// This block takes one quaternion request per clock unless back-pressure
// holds it, and returns one result per request, in order, through ten
// arithmetic stages plus one divider stage per result bit.
// The command in s_tuser selects add, subtract, Hamilton product a*b, divide
// a*conj(b)/|b|^2, inverse of a, or rotate a*b*conj(a)/|a|^2. All components
// are signed Q16.16. Each product is kept exact and rounded once, to nearest
// with ties away from zero, by a restoring divider whose depth sets the
// latency. Components that fall outside the 32-bit range clamp and raise
// the saturated flag. A zero squared magnitude in divide, inverse or rotate
// gives an all-zero result with divide_by_zero set. Unused command codes
// return zeros with both flags clear. Every stage has its own valid bit and
// fills bubbles, so back-pressure on the result side stalls only the stages
// that are full.
module quaternion_alu_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, 32 bits each, from bit 0 up
  input  logic [qalu_pkg::IN_DATA_W-1:0]  s_tdata,
  // command
  input  logic [qalu_pkg::CMD_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // r_x, r_y, r_z, r_w, 32 bits each, from bit 0 up
  output logic [qalu_pkg::OUT_DATA_W-1:0] m_tdata,
  // divide_by_zero, saturated, from bit 0 up
  output logic [1:0]                      m_tuser
);
  import qalu_pkg::*;

  localparam int ST_DIV = 8;
  localparam int ST_RND = ST_DIV + Q_W;
  localparam int ST_OUT = ST_RND + 1;
  localparam int NSTAGE = ST_OUT + 1;

  localparam logic [Q_W:0] LIM = (Q_W + 1)'(1) << (Q_W - 1);

  // Stage handshake: a stage may load when it is empty or moving on.
  logic [NSTAGE-1:0] v;
  logic [NSTAGE:0]   en;

  assign en[NSTAGE] = m_tready;
  for (genvar i = 0; i < NSTAGE; i++) begin : g_en
    assign en[i] = ~v[i] | en[i+1];
  end

  assign s_tready = en[0];
  assign m_tvalid = v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: request register.
  logic [CMD_W-1:0]         s0_cmd;
  logic signed [DATA_W-1:0] s0_a [4];
  logic signed [DATA_W-1:0] s0_b [4];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_cmd <= s_tuser;
      for (int k = 0; k < 4; k++) begin
        s0_a[k] <= s_tdata[k*DATA_W +: DATA_W];
        s0_b[k] <= s_tdata[(k+4)*DATA_W +: DATA_W];
      end
    end
  end

  // Stage 1: all pairwise products a[j]*b[k], the squares, and the sum or
  // difference used by add and subtract.
  logic [CMD_W-1:0]         s1_cmd;
  logic signed [DATA_W-1:0] s1_a [4];
  logic signed [PROD_W-1:0] s1_prod [4][4];
  logic signed [PROD_W-1:0] s1_sqa [4];
  logic signed [PROD_W-1:0] s1_sqb [4];
  logic signed [DATA_W:0]   s1_as [4];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_cmd <= s0_cmd;
      for (int j = 0; j < 4; j++) begin
        s1_a[j]   <= s0_a[j];
        s1_sqa[j] <= PROD_W'(s0_a[j]) * PROD_W'(s0_a[j]);
        s1_sqb[j] <= PROD_W'(s0_b[j]) * PROD_W'(s0_b[j]);
        s1_as[j]  <= (s0_cmd == CMD_SUB) ?
                     ((DATA_W + 1)'(s0_a[j]) - (DATA_W + 1)'(s0_b[j])) :
                     ((DATA_W + 1)'(s0_a[j]) + (DATA_W + 1)'(s0_b[j]));
        for (int k = 0; k < 4; k++) begin
          s1_prod[j][k] <= PROD_W'(s0_a[j]) * PROD_W'(s0_b[k]);
        end
      end
    end
  end

  // Stage 2: Hamilton product sums and squared magnitudes. For divide the
  // vector part of b is conjugated by flipping the sign of those terms.
  logic signed [SUM_W-1:0] m_sum [4];
  logic [DEN_W-1:0]        sqa_sum;
  logic [DEN_W-1:0]        sqb_sum;

  always_comb begin
    logic signed [SUM_W-1:0] term;
    logic                    flip;
    sqa_sum = '0;
    sqb_sum = '0;
    for (int r = 0; r < 4; r++) begin
      m_sum[r] = '0;
      for (int j = 0; j < 4; j++) begin
        term = SUM_W'(s1_prod[j][QIDX[r][j]]);
        flip = QNEG[r][j] ^ ((s1_cmd == CMD_DIV) && (QIDX[r][j] != COMP_W));
        m_sum[r] = flip ? (m_sum[r] - term) : (m_sum[r] + term);
      end
      sqa_sum = sqa_sum + DEN_W'($unsigned(s1_sqa[r]));
      sqb_sum = sqb_sum + DEN_W'($unsigned(s1_sqb[r]));
    end
  end

  logic [CMD_W-1:0]         s2_cmd;
  logic signed [DATA_W-1:0] s2_a [4];
  logic signed [SUM_W-1:0]  s2_m [4];
  logic [DEN_W-1:0]         s2_sqa;
  logic [DEN_W-1:0]         s2_sqb;
  logic signed [DATA_W:0]   s2_as [4];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_cmd <= s1_cmd;
      s2_sqa <= sqa_sum;
      s2_sqb <= sqb_sum;
      for (int k = 0; k < 4; k++) begin
        s2_a[k]  <= s1_a[k];
        s2_m[k]  <= m_sum[k];
        s2_as[k] <= s1_as[k];
      end
    end
  end

  // Stage 3: second product for rotate. Each 66-bit component of a*b is
  // split into a signed high half and an unsigned low half so that every
  // multiplier stays near 33 by 32 bits.
  logic [CMD_W-1:0]         s3_cmd;
  logic signed [DATA_W-1:0] s3_a [4];
  logic signed [SUM_W-1:0]  s3_m [4];
  logic [DEN_W-1:0]         s3_sqa;
  logic [DEN_W-1:0]         s3_sqb;
  logic signed [DATA_W:0]   s3_as [4];
  logic signed [PH_W-1:0]   s3_ph [4][4];
  logic signed [PL_W-1:0]   s3_pl [4][4];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_cmd <= s2_cmd;
      s3_sqa <= s2_sqa;
      s3_sqb <= s2_sqb;
      for (int j = 0; j < 4; j++) begin
        s3_a[j]  <= s2_a[j];
        s3_m[j]  <= s2_m[j];
        s3_as[j] <= s2_as[j];
        for (int k = 0; k < 4; k++) begin
          s3_ph[j][k] <= PH_W'($signed(s2_m[j][SUM_W-1:LO_W])) * PH_W'(s2_a[k]);
          s3_pl[j][k] <= PL_W'($signed({1'b0, s2_m[j][LO_W-1:0]})) * PL_W'(s2_a[k]);
        end
      end
    end
  end

  // Stage 4: recombine the split partial products.
  logic [CMD_W-1:0]         s4_cmd;
  logic signed [DATA_W-1:0] s4_a [4];
  logic signed [SUM_W-1:0]  s4_m [4];
  logic [DEN_W-1:0]         s4_sqa;
  logic [DEN_W-1:0]         s4_sqb;
  logic signed [DATA_W:0]   s4_as [4];
  logic signed [PP_W-1:0]   s4_pp [4][4];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_cmd <= s3_cmd;
      s4_sqa <= s3_sqa;
      s4_sqb <= s3_sqb;
      for (int j = 0; j < 4; j++) begin
        s4_a[j]  <= s3_a[j];
        s4_m[j]  <= s3_m[j];
        s4_as[j] <= s3_as[j];
        for (int k = 0; k < 4; k++) begin
          s4_pp[j][k] <= $signed({s3_ph[j][k], {LO_W{1'b0}}}) + PP_W'(s3_pl[j][k]);
        end
      end
    end
  end

  // Stage 5: finish the rotate product (a*b)*conj(a), then pick the
  // numerator and denominator for the command.
  logic signed [NUM_W-1:0] rot_sum [4];
  logic signed [NUM_W-1:0] num_sel [4];
  logic [DEN_W-1:0]        den_sel;
  logic                    dz_sel;
  logic                    zero_sel;

  always_comb begin
    logic signed [NUM_W-1:0] term;
    logic                    flip;
    for (int r = 0; r < 4; r++) begin
      rot_sum[r] = '0;
      for (int j = 0; j < 4; j++) begin
        term = NUM_W'(s4_pp[j][QIDX[r][j]]);
        flip = QNEG[r][j] ^ (QIDX[r][j] != COMP_W);
        rot_sum[r] = flip ? (rot_sum[r] - term) : (rot_sum[r] + term);
      end
    end
  end

  always_comb begin
    zero_sel = 1'b0;
    den_sel  = DEN_W'(1);
    for (int k = 0; k < 4; k++) begin
      num_sel[k] = '0;
    end
    unique case (s4_cmd) inside
      CMD_ADD, CMD_SUB: begin
        for (int k = 0; k < 4; k++) begin
          num_sel[k] = NUM_W'(s4_as[k]);
        end
      end
      CMD_MUL: begin
        den_sel = DEN_W'(1) << FRAC_BITS;
        for (int k = 0; k < 4; k++) begin
          num_sel[k] = NUM_W'(s4_m[k]);
        end
      end
      CMD_DIV: begin
        den_sel = s4_sqb;
        for (int k = 0; k < 4; k++) begin
          num_sel[k] = NUM_W'(s4_m[k]) <<< FRAC_BITS;
        end
      end
      CMD_INV: begin
        den_sel = s4_sqa;
        for (int k = 0; k < 4; k++) begin
          num_sel[k] = NUM_W'(s4_a[k]) <<< (2 * FRAC_BITS);
          if (k != 3) begin
            num_sel[k] = -num_sel[k];
          end
        end
      end
      CMD_ROT: begin
        den_sel = s4_sqa;
        for (int k = 0; k < 4; k++) begin
          num_sel[k] = rot_sum[k];
        end
      end
      default: begin
        zero_sel = 1'b1;
      end
    endcase
    dz_sel = ~zero_sel && (den_sel == '0);
  end

  logic signed [NUM_W-1:0] s5_num [4];
  logic [DEN_W-1:0]        s5_den;
  logic                    s5_dz;
  logic                    s5_zero;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_den  <= den_sel;
      s5_dz   <= dz_sel;
      s5_zero <= zero_sel;
      for (int k = 0; k < 4; k++) begin
        s5_num[k] <= num_sel[k];
      end
    end
  end

  // Stage 6: sign and magnitude.
  logic [NUM_W-1:0] s6_mag [4];
  logic [3:0]       s6_neg;
  logic [DEN_W-1:0] s6_den;
  logic             s6_dz;
  logic             s6_zero;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_den  <= s5_den;
      s6_dz   <= s5_dz;
      s6_zero <= s5_zero;
      for (int k = 0; k < 4; k++) begin
        s6_neg[k] <= s5_num[k][NUM_W-1];
        s6_mag[k] <= s5_num[k][NUM_W-1] ? $unsigned(-s5_num[k]) : $unsigned(s5_num[k]);
      end
    end
  end

  // Stage 7: a quotient of 2^Q_W or more always clamps, so the divider only
  // has to produce Q_W bits. The remainder starts from the high part.
  logic [REM_W-1:0] s7_rem [4];
  logic [Q_W-1:0]   s7_qs [4];
  logic [DEN_W-1:0] s7_den;
  side_t            s7_side;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_den       <= s6_den;
      s7_side.neg  <= s6_neg;
      s7_side.dz   <= s6_dz;
      s7_side.zero <= s6_zero;
      for (int k = 0; k < 4; k++) begin
        s7_side.ovf[k] <= (s6_mag[k] >= NUM_W'({s6_den, {Q_W{1'b0}}}));
        s7_rem[k]      <= REM_W'(s6_mag[k] >> Q_W);
        s7_qs[k]       <= s6_mag[k][Q_W-1:0];
      end
    end
  end

  logic [REM_W-1:0] dv_rem [4];
  logic [Q_W-1:0]   dv_qs [4];
  logic [DEN_W-1:0] dv_den;
  side_t            dv_side;

  qalu_divider u_divider (
    .clk      (clk),
    .en       (en[ST_DIV +: Q_W]),
    .rem_in   (s7_rem),
    .qs_in    (s7_qs),
    .den_in   (s7_den),
    .side_in  (s7_side),
    .rem_out  (dv_rem),
    .qs_out   (dv_qs),
    .den_out  (dv_den),
    .side_out (dv_side)
  );

  // Rounding stage: round half away from zero on the magnitude.
  logic [Q_W:0] rnd_q [4];
  side_t        rnd_side;

  always_ff @(posedge clk) begin
    if (en[ST_RND]) begin
      rnd_side <= dv_side;
      for (int k = 0; k < 4; k++) begin
        rnd_q[k] <= (Q_W + 1)'(dv_qs[k]) +
                    (Q_W + 1)'({dv_rem[k], 1'b0} >= (REM_W + 1)'(dv_den));
      end
    end
  end

  // Output stage: saturate, restore the sign and apply the special cases.
  logic [Q_W-1:0] fin_val [4];
  logic [3:0]     fin_sat;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fin_sat[k] = rnd_side.ovf[k] ||
                   (rnd_side.neg[k] ? (rnd_q[k] > LIM) : (rnd_q[k] >= LIM));
      if (fin_sat[k]) begin
        fin_val[k] = rnd_side.neg[k] ? {1'b1, {(Q_W - 1){1'b0}}} :
                                       {1'b0, {(Q_W - 1){1'b1}}};
      end else begin
        fin_val[k] = rnd_side.neg[k] ? Q_W'(-rnd_q[k]) : Q_W'(rnd_q[k]);
      end
    end
  end

  logic signed [DATA_W-1:0] r_comp [4];
  logic                     r_dz;
  logic                     r_sat;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      r_dz  <= rnd_side.dz;
      r_sat <= ~rnd_side.dz && ~rnd_side.zero && (|fin_sat);
      for (int k = 0; k < 4; k++) begin
        r_comp[k] <= (rnd_side.dz || rnd_side.zero) ? '0 : DATA_W'($signed(fin_val[k]));
      end
    end
  end

  assign m_tdata = {r_comp[3], r_comp[2], r_comp[1], r_comp[0]};
  assign m_tuser = {r_sat, r_dz};

endmodule
